[hw/rtl/srtp_pkg.sv]
// ----------------------------------------------------------------------------
// srtp_pkg
// Shared widths, op codes, register indexes and controller commands for the
// sound RAM transfer port.
// ----------------------------------------------------------------------------
package srtp_pkg;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 20;
    localparam int VALUE_W  = 16;
    localparam int XFER_W   = 18;   // transfer word address
    localparam int DADDR_W  = 19;   // word address taken from a byte address

    localparam int REG_COUNT = 256;
    localparam int REG_AW    = 8;

    localparam int RAM_WORDS_DEF = 262144;

    localparam logic [OP_W-1:0] OP_REG_WRITE    = 3'd0;
    localparam logic [OP_W-1:0] OP_REG_READ     = 3'd1;
    localparam logic [OP_W-1:0] OP_DMA_READ     = 3'd2;
    localparam logic [OP_W-1:0] OP_DMA_WRITE    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIRECT_READ  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIRECT_WRITE = 3'd5;

    localparam logic [INDEX_W-1:0] REG_XFER_ADDR = 20'd211;
    localparam logic [INDEX_W-1:0] REG_XFER_DATA = 20'd212;

    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // perform the memory access and address update
    } t_dp_cmd;

endpackage

[hw/rtl/sound_ram_transfer_port.sv]
// ----------------------------------------------------------------------------
// sound_ram_transfer_port
// Register window and sound RAM transfer port of a sound unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_op, i_index and i_value and raise start; the item is taken on a
//   rising edge where start is high and busy is low. busy then stays high
//   until the result has been shown.
//   Each item gives one result: o_read_data is valid while o_strobe is high,
//   for exactly one cycle, in S_RESP, which follows the S_EXEC access state.
//   The receiver has no way to stall and must take it then.
//   An item passes through three steps (capture, one RAM / mirror access
//   with the address update, result), and no new item is taken until the
//   result has been shown; the three-step sequencer in the controller sets this.
//   Reset (synchronous, active low) zeroes the transfer address and the
//   register mirror through per-entry valid bits, so it takes effect at
//   once with no clearing pass. Sound RAM content is undefined until
//   written.
// ----------------------------------------------------------------------------
module sound_ram_transfer_port #(
    parameter int RAM_WORDS = srtp_pkg::RAM_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [srtp_pkg::OP_W-1:0]    i_op,
    input  logic [srtp_pkg::INDEX_W-1:0] i_index,
    input  logic [srtp_pkg::VALUE_W-1:0] i_value,
    output logic                         o_strobe,
    output logic [srtp_pkg::VALUE_W-1:0] o_read_data
);
    import srtp_pkg::*;

    t_dp_cmd w_cmd;

    srtp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (w_cmd)
    );

    srtp_datapath #(
        .RAM_WORDS (RAM_WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_read_data (o_read_data)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_cmd.exec)
        else $error("accepted item did not reach the access cycle");

    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_strobe)
        else $error("access cycle not followed by a result");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy && !w_cmd.load))
        else $error("result shown while a new item could be taken");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!o_strobe && !busy))
        else $error("result held longer than one cycle");

endmodule

[hw/rtl/srtp_ctrl.sv]
// ----------------------------------------------------------------------------
// srtp_ctrl
// Sequencer: accept an item, run its access (S_EXEC), present the result.
// ----------------------------------------------------------------------------
module srtp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_strobe,
    output srtp_pkg::t_dp_cmd o_cmd
);
    import srtp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state  <= S_RESP;
                    r_strobe <= 1'b1;
                end
                S_RESP: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_busy   <= 1'b0;
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = r_busy;
    assign o_strobe   = r_strobe;
    assign o_cmd.load = start && !r_busy;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

[hw/rtl/srtp_datapath.sv]
// ----------------------------------------------------------------------------
// srtp_datapath
// Register mirror, sound RAM, transfer address and result selection.
// ----------------------------------------------------------------------------
module srtp_datapath #(
    parameter int RAM_WORDS = srtp_pkg::RAM_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srtp_pkg::t_dp_cmd            i_cmd,
    input  logic [srtp_pkg::OP_W-1:0]    i_op,
    input  logic [srtp_pkg::INDEX_W-1:0] i_index,
    input  logic [srtp_pkg::VALUE_W-1:0] i_value,
    output logic [srtp_pkg::VALUE_W-1:0] o_read_data
);
    import srtp_pkg::*;

    localparam int                 RAM_AW    = $clog2(RAM_WORDS);
    localparam logic [DADDR_W-1:0] RAM_LIMIT = DADDR_W'(RAM_WORDS);

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_MIRROR,
        SEL_RAM,
        SEL_ADDR
    } t_sel;

    // captured item
    logic [OP_W-1:0]    r_op;
    logic [INDEX_W-1:0] r_index;
    logic [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_index <= i_index;
            r_value <= i_value;
        end
    end

    // decode
    logic reg_ok, is_xfer_addr, is_xfer_data;
    logic port_rd, port_wr, direct_rd, direct_wr, mirror_wr;

    always_comb begin
        reg_ok       = (r_index[INDEX_W-1:REG_AW] == '0);
        is_xfer_addr = (r_index == REG_XFER_ADDR);
        is_xfer_data = (r_index == REG_XFER_DATA);
        mirror_wr    = (r_op == OP_REG_WRITE) && reg_ok;
        port_wr      = (r_op == OP_DMA_WRITE) || (mirror_wr && is_xfer_data);
        port_rd      = (r_op == OP_DMA_READ) || ((r_op == OP_REG_READ) && is_xfer_data);
        direct_rd    = (r_op == OP_DIRECT_READ);
        direct_wr    = (r_op == OP_DIRECT_WRITE);
    end

    // transfer address
    logic [XFER_W-1:0]  r_xfer_addr;
    logic [XFER_W-1:0]  n_xfer_addr;
    logic [XFER_W-1:0]  xfer_inc;

    always_comb begin
        xfer_inc    = r_xfer_addr + 1'b1;
        n_xfer_addr = r_xfer_addr;
        if (mirror_wr && is_xfer_addr) begin
            n_xfer_addr = {r_value, 2'b00};
        end else if (port_rd || port_wr) begin
            n_xfer_addr = ({1'b0, xfer_inc} >= RAM_LIMIT) ? '0 : xfer_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfer_addr <= '0;
        end else if (i_cmd.exec) begin
            r_xfer_addr <= n_xfer_addr;
        end
    end

    // sound RAM
    logic [DADDR_W-1:0] ram_addr;
    logic               ram_ok;
    logic               ram_we;
    logic               ram_re;
    logic [RAM_AW-1:0]  ram_idx;
    logic [VALUE_W-1:0] ram_mem [RAM_WORDS];
    logic [VALUE_W-1:0] r_ram_q;

    always_comb begin
        ram_addr = (direct_rd || direct_wr) ? r_index[INDEX_W-1:1] : {1'b0, r_xfer_addr};
        ram_ok   = (ram_addr < RAM_LIMIT);
        ram_idx  = ram_addr[RAM_AW-1:0];
        ram_we   = i_cmd.exec && ram_ok && (port_wr || direct_wr);
        ram_re   = i_cmd.exec && ram_ok && (port_rd || direct_rd);
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            ram_mem[ram_idx] <= r_value;
        end
        if (ram_re) begin
            r_ram_q <= ram_mem[ram_idx];
        end
    end

    // register mirror; entries never written since reset read as zero
    logic [VALUE_W-1:0]   mir_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_mir_vld;
    logic [VALUE_W-1:0]   r_mir_q;
    logic                 r_mir_vq;
    logic [REG_AW-1:0]    mir_idx;

    assign mir_idx = r_index[REG_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mirror_wr) begin
            mir_mem[mir_idx] <= r_value;
        end
        if (i_cmd.exec) begin
            r_mir_q  <= mir_mem[mir_idx];
            r_mir_vq <= r_mir_vld[mir_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mir_vld <= '0;
        end else if (i_cmd.exec && mirror_wr) begin
            r_mir_vld[mir_idx] <= 1'b1;
        end
    end

    // result selection
    t_sel              r_sel;
    t_sel              n_sel;
    logic [VALUE_W-1:0] r_addr_q;

    always_comb begin
        n_sel = SEL_ZERO;
        if ((port_rd || direct_rd) && ram_ok) begin
            n_sel = SEL_RAM;
        end else if ((r_op == OP_REG_READ) && is_xfer_addr) begin
            n_sel = SEL_ADDR;
        end else if ((r_op == OP_REG_READ) && reg_ok && !is_xfer_data) begin
            n_sel = SEL_MIRROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_sel    <= n_sel;
            r_addr_q <= r_xfer_addr[XFER_W-1:2];
        end
    end

    always_comb begin
        case (r_sel)
            SEL_RAM:    o_read_data = r_ram_q;
            SEL_ADDR:   o_read_data = r_addr_q;
            SEL_MIRROR: o_read_data = r_mir_vq ? r_mir_q : '0;
            default:    o_read_data = '0;
        endcase
    end

endmodule
